/* rtl/core/json_string_utf8_to_utf16_decoder_core_assert.svh */
// ----------------------------------------------------------------------------
// json string decoder assertion macros
// concurrent checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH
`define JSON_STRING_UTF8_TO_UTF16_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define JSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");
// expression must never be true outside reset
`define JSU_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define JSU_ASSERT(lbl, clk, rstn, prop)
`define JSU_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* rtl/core/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, status codes and character constants of the json decoder
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result status codes
  localparam logic [1:0] ST_UNIT    = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_BADESC  = 2'd2;
  localparam logic [1:0] ST_BADUTF8 = 2'd3;

  // default depth of the queue between front and back
  localparam int unsigned JSU_QUEUE_DEPTH = 4;

  // code point limits and surrogate bases
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [5:0]  HI_SURR    = 6'h36;  // 0xd800 >> 10
  localparam logic [5:0]  LO_SURR    = 6'h37;  // 0xdc00 >> 10

  // byte values
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] LEAD_MIN     = 8'hc2;
  localparam logic [7:0] LEAD_2_MAX   = 8'hdf;
  localparam logic [7:0] LEAD_3_MAX   = 8'hef;
  localparam logic [7:0] LEAD_MAX     = 8'hf4;
  localparam logic [7:0] LEAD_E0      = 8'he0;
  localparam logic [7:0] LEAD_ED      = 8'hed;
  localparam logic [7:0] LEAD_F0      = 8'hf0;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] CONT_MAX     = 8'hbf;
  localparam logic [7:0] CONT_E0_MIN  = 8'ha0;
  localparam logic [7:0] CONT_ED_MAX  = 8'h9f;
  localparam logic [7:0] CONT_F0_MIN  = 8'h90;
  localparam logic [7:0] CONT_F4_MAX  = 8'h8f;

  // one decoded event handed from front to back
  typedef struct packed {
    logic [20:0] value;   // code point or code unit, zero for non-unit status
    logic [1:0]  status;
  } jsu_job_t;

  // simple escape letters: bit 8 flags a known letter, bits 7:0 the character
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h30:   r = {1'b1, 8'h00};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h74:   r = {1'b1, 8'h09};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h76:   r = {1'b1, 8'h0b};
      8'h66:   r = {1'b1, 8'h0c};
      8'h72:   r = {1'b1, 8'h0d};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h22:   r = {1'b1, 8'h22};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/json_string_utf8_to_utf16_decoder_core.sv */
// ----------------------------------------------------------------------------
// json_string_utf8_to_utf16_decoder_core
// json string body unescaper, utf-8 bytes in, utf-16 code units out
// ----------------------------------------------------------------------------
// One item is one byte of a json string body (opening quote already taken,
// closing quote included). The front classifies each byte as it is accepted:
// plain ascii, backslash escapes, \u with four hex digits (digit value taken
// unchecked) and range-checked utf-8 sequences. Finished events go into a
// short queue (QueueDepth entries) and the back turns each into one result,
// or into a high/low surrogate pair for code points above 0xffff, with
// last_of_run_o marking the final result of a byte. An unescaped quote gives
// status 1, an unknown escape status 2 and ill-formed utf-8 status 3, all with
// code unit zero; the decoder then carries on in plain mode. Events pass the
// queue, then the output register. The front takes one byte per cycle while
// the queue has room and the back hands out one result per cycle while popped,
// so one byte per cycle is sustained but a surrogate pair holds the back for
// its low half; full rises only when the queue fills behind a stalled output.
// ----------------------------------------------------------------------------
module json_string_utf8_to_utf16_decoder_core #(
  parameter int unsigned QueueDepth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic [1:0]  status_o,
  output logic        last_of_run_o
);
  import jsu_pkg::*;

  logic     accept;
  logic     job_valid;
  jsu_job_t job_in;
  jsu_job_t job_head;
  logic     job_empty;
  logic     job_pop;

  // a byte is taken whenever the queue has room
  assign accept = push && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_in_i   (byte_in_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // decouples the classifier from a stalled result side
  jsu_job_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_head)
  );

  // output register plus pending low surrogate
  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_empty_i   (job_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .code_unit_o   (code_unit_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* rtl/core/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// byte classifier: escape, hex and utf-8 mode tracking, one byte per cycle
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_in_i,
  output logic             job_valid_o,
  output jsu_pkg::jsu_job_t job_o
);
  import jsu_pkg::*;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;
  localparam logic [1:0] MODE_UTF8  = 2'd3;

  logic [1:0]  mode_q, mode_d;
  logic [1:0]  rem_q, rem_d;
  logic [20:0] acc_q, acc_d;
  logic [7:0]  lead_q, lead_d;
  logic        first_q, first_d;

  logic [4:0]  hex_hi;
  logic [5:0]  digit;
  logic [15:0] hex_acc;
  logic [20:0] cont_acc;
  logic [7:0]  lo, hi;
  logic [8:0]  esc;
  logic [1:0]  rem_dec;

  always_comb begin
    // digit value (b & 0xf) + (b >> 6) * 9, unchecked
    hex_hi   = {byte_in_i[7:6], 3'b000} + {3'b000, byte_in_i[7:6]};
    digit    = {2'b00, byte_in_i[3:0]} + {1'b0, hex_hi};
    hex_acc  = {acc_q[11:0], 4'h0} | {10'h000, digit};
    cont_acc = {acc_q[14:0], byte_in_i[5:0]};
    esc      = esc_map(byte_in_i);
    rem_dec  = rem_q - 2'd1;

    lo = CONT_MIN;
    hi = CONT_MAX;
    if (first_q) begin
      case (lead_q)
        LEAD_E0: lo = CONT_E0_MIN;
        LEAD_ED: hi = CONT_ED_MAX;
        LEAD_F0: lo = CONT_F0_MIN;
        LEAD_MAX: hi = CONT_F4_MAX;
        default: ;
      endcase
    end

    mode_d       = mode_q;
    rem_d        = rem_q;
    acc_d        = acc_q;
    lead_d       = lead_q;
    first_d      = first_q;
    job_valid_o  = 1'b0;
    job_o.value  = '0;
    job_o.status = ST_UNIT;

    if (accept_i) begin
      unique case (mode_q)
        MODE_PLAIN: begin
          if (byte_in_i == CH_QUOTE) begin
            job_valid_o  = 1'b1;
            job_o.status = ST_END;
          end else if (byte_in_i == CH_BACKSLASH) begin
            mode_d = MODE_ESC;
          end else if (!byte_in_i[7]) begin
            job_valid_o = 1'b1;
            job_o.value = {13'h0000, byte_in_i};
          end else if (byte_in_i < LEAD_MIN || byte_in_i > LEAD_MAX) begin
            job_valid_o  = 1'b1;
            job_o.status = ST_BADUTF8;
          end else begin
            if (byte_in_i <= LEAD_2_MAX) begin
              rem_d = 2'd1;
              acc_d = {16'h0000, byte_in_i[4:0]};
            end else if (byte_in_i <= LEAD_3_MAX) begin
              rem_d = 2'd2;
              acc_d = {17'h00000, byte_in_i[3:0]};
            end else begin
              rem_d = 2'd3;
              acc_d = {18'h00000, byte_in_i[2:0]};
            end
            lead_d  = byte_in_i;
            first_d = 1'b1;
            mode_d  = MODE_UTF8;
          end
        end
        MODE_ESC: begin
          mode_d = MODE_PLAIN;
          if (byte_in_i == CH_U) begin
            mode_d = MODE_HEX;
            rem_d  = 2'd3;
            acc_d  = '0;
          end else if (esc[8]) begin
            job_valid_o = 1'b1;
            job_o.value = {13'h0000, esc[7:0]};
          end else begin
            job_valid_o  = 1'b1;
            job_o.status = ST_BADESC;
          end
        end
        MODE_HEX: begin
          acc_d = {5'h00, hex_acc};
          if (rem_q == 2'd0) begin
            mode_d      = MODE_PLAIN;
            job_valid_o = 1'b1;
            job_o.value = {5'h00, hex_acc};
          end else begin
            rem_d = rem_dec;
          end
        end
        MODE_UTF8: begin
          first_d = 1'b0;
          if (byte_in_i < lo || byte_in_i > hi) begin
            mode_d       = MODE_PLAIN;
            rem_d        = 2'd0;
            job_valid_o  = 1'b1;
            job_o.status = ST_BADUTF8;
          end else begin
            acc_d = cont_acc;
            rem_d = rem_dec;
            if (rem_dec == 2'd0) begin
              mode_d      = MODE_PLAIN;
              job_valid_o = 1'b1;
              job_o.value = cont_acc;
            end
          end
        end
        default: mode_d = MODE_PLAIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      rem_q   <= 2'd0;
      acc_q   <= '0;
      lead_q  <= '0;
      first_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      lead_q  <= lead_d;
      first_q <= first_d;
    end
  end

endmodule

/* rtl/core/jsu_job_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_job_fifo
// short queue of decoded events between front and back
// ----------------------------------------------------------------------------
`include "json_string_utf8_to_utf16_decoder_core_assert.svh"

module jsu_job_fifo #(
  parameter int unsigned Depth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsu_pkg::jsu_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output jsu_pkg::jsu_job_t job_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsu_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `JSU_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntFull)
  `JSU_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `JSU_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

/* rtl/core/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// expands events into code units, splits supplementary points into pairs
// ----------------------------------------------------------------------------
`include "json_string_utf8_to_utf16_decoder_core_assert.svh"

module jsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  jsu_pkg::jsu_job_t job_i,
  output logic              job_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [15:0]       code_unit_o,
  output logic [1:0]        status_o,
  output logic              last_of_run_o
);
  import jsu_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [15:0] unit_q, unit_d;
  logic [1:0]  status_q, status_d;
  logic        last_q, last_d;
  logic        pend_q, pend_d;
  logic [9:0]  pend_lo_q, pend_lo_d;

  logic        load;
  logic        is_pair;
  logic [20:0] supp;

  assign load    = !out_valid_q || pop_i;
  assign is_pair = (job_i.status == ST_UNIT) && (job_i.value[20:16] != 5'h00);
  assign supp    = job_i.value - SUPP_BASE;

  always_comb begin
    out_valid_d = out_valid_q;
    unit_d      = unit_q;
    status_d    = status_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_lo_d   = pend_lo_q;
    job_pop_o   = 1'b0;
    if (load) begin
      if (pend_q) begin
        // low half of a surrogate pair
        out_valid_d = 1'b1;
        unit_d      = {LO_SURR, pend_lo_q};
        status_d    = ST_UNIT;
        last_d      = 1'b1;
        pend_d      = 1'b0;
      end else if (!job_empty_i) begin
        job_pop_o   = 1'b1;
        out_valid_d = 1'b1;
        status_d    = job_i.status;
        if (is_pair) begin
          unit_d    = {HI_SURR, supp[19:10]};
          last_d    = 1'b0;
          pend_d    = 1'b1;
          pend_lo_d = supp[9:0];
        end else begin
          unit_d = job_i.value[15:0];
          last_d = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q    <= unit_d;
    status_q  <= status_d;
    last_q    <= last_d;
    pend_lo_q <= pend_lo_d;
  end

  assign empty_o       = !out_valid_q;
  assign code_unit_o   = unit_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  `JSU_ASSERT(a_pend_high_shown, clk_i, rst_ni, pend_q |-> (out_valid_q && !last_q))
  `JSU_ASSERT(a_err_zero, clk_i, rst_ni, (out_valid_q && status_q != ST_UNIT) |-> (unit_q == '0))
  `JSU_ASSERT_NEVER(a_pop_while_pend, clk_i, rst_ni, job_pop_o && pend_q)

endmodule

/* verif/json_decoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_decoder_checker
// watches both queue ports of the json string decoder, predicts the utf-16
// code units each accepted byte must give and compares them in arrival order
// ----------------------------------------------------------------------------
module json_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  byte_in_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [15:0] code_unit_i,
  input  logic [1:0]  status_i,
  input  logic        last_of_run_i,
  output int          mismatches_o,
  output int          units_pending_o,
  output int          bytes_taken_o,
  output int          results_taken_o,
  output int          surrogates_o,
  output int          markers_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {MODE_TEXT, MODE_ESCAPE, MODE_HEX, MODE_UTF8} decode_mode_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        last_of_run;
  } decoded_unit_t;

  // keep the log short when the block is badly broken
  localparam int PrintLimit = 40;

  decode_mode_e  mode_q;
  logic [1:0]    left_q;
  logic [20:0]   acc_q;
  logic [7:0]    lead_q;
  logic          second_q;
  decoded_unit_t expected_units[$];

  task automatic report_mismatch(input string what);
    if (mismatches_o < PrintLimit) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches_o++;
  endtask

  task automatic expect_unit(input logic [15:0] cu, input logic [1:0] st, input logic last);
    expected_units.push_back(decoded_unit_t'{cu, st, last});
  endtask

  // one code unit, or a surrogate pair above the basic plane
  task automatic expect_point(input logic [20:0] cp);
    logic [20:0] offset;
    if (cp < SUPP_BASE) begin
      expect_unit(cp[15:0], ST_UNIT, 1'b1);
    end else begin
      offset = cp - SUPP_BASE;
      expect_unit({HI_SURR, offset[19:10]}, ST_UNIT, 1'b0);
      expect_unit({LO_SURR, offset[9:0]}, ST_UNIT, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0]  lo_lim;
    logic [7:0]  hi_lim;
    logic [5:0]  digit;
    logic [15:0] hex_acc;
    case (mode_q)
      MODE_TEXT: begin
        if (b == CH_QUOTE) begin
          expect_unit(16'h0000, ST_END, 1'b1);
        end else if (b == CH_BACKSLASH) begin
          mode_q = MODE_ESCAPE;
        end else if (b < CONT_MIN) begin
          expect_unit({8'h00, b}, ST_UNIT, 1'b1);
        end else if (b < LEAD_MIN || b > LEAD_MAX) begin
          expect_unit(16'h0000, ST_BADUTF8, 1'b1);
        end else begin
          if (b <= LEAD_2_MAX) begin
            left_q = 2'd1;
            acc_q  = {16'h0000, b[4:0]};
          end else if (b <= LEAD_3_MAX) begin
            left_q = 2'd2;
            acc_q  = {17'h00000, b[3:0]};
          end else begin
            left_q = 2'd3;
            acc_q  = {18'h00000, b[2:0]};
          end
          lead_q   = b;
          second_q = 1'b1;
          mode_q   = MODE_UTF8;
        end
      end
      MODE_ESCAPE: begin
        mode_q = MODE_TEXT;
        case (b)
          "0":  expect_unit(16'h0000, ST_UNIT, 1'b1);
          "a":  expect_unit(16'h0007, ST_UNIT, 1'b1);
          "b":  expect_unit(16'h0008, ST_UNIT, 1'b1);
          "t":  expect_unit(16'h0009, ST_UNIT, 1'b1);
          "n":  expect_unit(16'h000a, ST_UNIT, 1'b1);
          "v":  expect_unit(16'h000b, ST_UNIT, 1'b1);
          "f":  expect_unit(16'h000c, ST_UNIT, 1'b1);
          "r":  expect_unit(16'h000d, ST_UNIT, 1'b1);
          "/", CH_BACKSLASH, CH_QUOTE: expect_unit({8'h00, b}, ST_UNIT, 1'b1);
          CH_U: begin
            mode_q = MODE_HEX;
            left_q = 2'd3;
            acc_q  = '0;
          end
          default: expect_unit(16'h0000, ST_BADESC, 1'b1);
        endcase
      end
      MODE_HEX: begin
        // digit value is not checked, high bits add nines and overlap the shift
        digit   = {2'b00, b[3:0]} + {4'b0000, b[7:6]} * 6'd9;
        hex_acc = {acc_q[11:0], 4'h0} | {10'h000, digit};
        acc_q   = {5'h00, hex_acc};
        if (left_q == 2'd0) begin
          mode_q = MODE_TEXT;
          expect_unit(hex_acc, ST_UNIT, 1'b1);
        end else begin
          left_q = left_q - 2'd1;
        end
      end
      default: begin
        lo_lim = CONT_MIN;
        hi_lim = CONT_MAX;
        if (second_q) begin
          if (lead_q == LEAD_E0) lo_lim = CONT_E0_MIN;
          else if (lead_q == LEAD_ED) hi_lim = CONT_ED_MAX;
          else if (lead_q == LEAD_F0) lo_lim = CONT_F0_MIN;
          else if (lead_q == LEAD_MAX) hi_lim = CONT_F4_MAX;
        end
        second_q = 1'b0;
        if (b < lo_lim || b > hi_lim) begin
          mode_q = MODE_TEXT;
          left_q = 2'd0;
          expect_unit(16'h0000, ST_BADUTF8, 1'b1);
        end else begin
          acc_q  = {acc_q[14:0], b[5:0]};
          left_q = left_q - 2'd1;
          if (left_q == 2'd0) begin
            mode_q = MODE_TEXT;
            expect_point(acc_q);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    decoded_unit_t want;
    if (!rst_ni) begin
      mode_q   = MODE_TEXT;
      left_q   = '0;
      acc_q    = '0;
      lead_q   = '0;
      second_q = 1'b0;
      expected_units.delete();
      units_pending_o = 0;
    end else begin
      if (push_i && !full_i) begin
        decode_byte(byte_in_i);
        bytes_taken_o++;
      end
      if (pop_i && !empty_i) begin
        results_taken_o++;
        if (status_i !== ST_UNIT) markers_o++;
        else if (code_unit_i[15:11] === 5'b11011) surrogates_o++;
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("result %h status %0d with nothing expected",
                                    code_unit_i, status_i));
        end else begin
          want = expected_units.pop_front();
          if (code_unit_i !== want.code_unit)
            report_mismatch($sformatf("code unit %h, expected %h",
                                      code_unit_i, want.code_unit));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (code unit %h)",
                                      status_i, want.status, want.code_unit));
          if (last_of_run_i !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b (code unit %h)",
                                      last_of_run_i, want.last_of_run, want.code_unit));
        end
      end
      units_pending_o = expected_units.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives json string body bytes into the utf-8 to utf-16 decoder with random
// gaps and output stalls, and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;

  localparam int RandomBytes   = 750;
  localparam int CalmTail      = 120;  // last bytes run with no idling
  localparam int HoldCycles    = 48;   // long output hold-off, fills the queue
  localparam int DrainCycles   = 8;    // margin to catch stray extra results
  // longest correct quiet stretch is the hold-off plus a stall burst
  localparam int WatchdogLimit = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  byte_in;
  logic        empty;
  logic        pop;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic        last_of_run;

  int mismatches;
  int units_pending;
  int bytes_taken;
  int results_taken;
  int surrogates;
  int markers;

  logic [7:0] byte_plan[$];
  int         bytes_sent;
  int         quiet_cycles;
  bit         calm;
  bit         holding;
  bit         reset_done;

  // escape letters with a fixed meaning, and characters for \u digits
  string escape_letters = "0abtnvfr/\\\"";
  string hex_chars      = "0123456789abcdefABCDEF";

  json_string_utf8_to_utf16_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .byte_in_i     (byte_in),
    .empty         (empty),
    .pop           (pop),
    .code_unit_o   (code_unit),
    .status_o      (status),
    .last_of_run_o (last_of_run)
  );

  json_decoder_checker decode_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .byte_in_i       (byte_in),
    .empty_i         (empty),
    .pop_i           (pop),
    .code_unit_i     (code_unit),
    .status_i        (status),
    .last_of_run_i   (last_of_run),
    .mismatches_o    (mismatches),
    .units_pending_o (units_pending),
    .bytes_taken_o   (bytes_taken),
    .results_taken_o (results_taken),
    .surrogates_o    (surrogates),
    .markers_o       (markers)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // any continuation byte
  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(CONT_MIN, CONT_MAX));
  endfunction

  // second byte of a sequence, inside the narrowed range of its lead
  function automatic logic [7:0] rand_second(input logic [7:0] lead);
    if (lead == LEAD_E0) return 8'($urandom_range(CONT_E0_MIN, CONT_MAX));
    if (lead == LEAD_ED) return 8'($urandom_range(CONT_MIN, CONT_ED_MAX));
    if (lead == LEAD_F0) return 8'($urandom_range(CONT_F0_MIN, CONT_MAX));
    if (lead == LEAD_MAX) return 8'($urandom_range(CONT_MIN, CONT_F4_MAX));
    return rand_cont();
  endfunction

  // mostly real hex characters, sometimes any byte since digits go unchecked
  function automatic logic [7:0] rand_hex_digit();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
  endfunction

  // append one random token of a string body to the plan
  task automatic plan_token();
    logic [7:0] lead;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // plain ascii, quote and backslash included now and then
      byte_plan.push_back(8'($urandom_range(0, 8'h7f)));
    end else if (pick < 36) begin
      byte_plan.push_back(CH_QUOTE);
    end else if (pick < 48) begin
      byte_plan.push_back(CH_BACKSLASH);
      byte_plan.push_back(escape_letters[$urandom_range(0, escape_letters.len() - 1)]);
    end else if (pick < 56) begin
      byte_plan.push_back(CH_BACKSLASH);
      byte_plan.push_back(CH_U);
      repeat (4) byte_plan.push_back(rand_hex_digit());
    end else if (pick < 66) begin
      byte_plan.push_back(8'($urandom_range(LEAD_MIN, LEAD_2_MAX)));
      byte_plan.push_back(rand_cont());
    end else if (pick < 76) begin
      lead = 8'($urandom_range(LEAD_E0, LEAD_3_MAX));
      byte_plan.push_back(lead);
      byte_plan.push_back(rand_second(lead));
      byte_plan.push_back(rand_cont());
    end else if (pick < 86) begin
      lead = 8'($urandom_range(LEAD_F0, LEAD_MAX));
      byte_plan.push_back(lead);
      byte_plan.push_back(rand_second(lead));
      byte_plan.push_back(rand_cont());
      byte_plan.push_back(rand_cont());
    end else if (pick < 92) begin
      // broken sequence: a good lead, then whatever byte
      lead = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
      byte_plan.push_back(lead);
      if (lead > LEAD_2_MAX && $urandom_range(0, 1) == 1) byte_plan.push_back(rand_second(lead));
      byte_plan.push_back(8'($urandom));
    end else if (pick < 95) begin
      // escape with an arbitrary letter, mostly unknown
      byte_plan.push_back(CH_BACKSLASH);
      byte_plan.push_back(8'($urandom));
    end else begin
      byte_plan.push_back(8'($urandom));
    end
  endtask

  // offer one byte and wait until the decoder takes it; entered after a falling
  // edge and left after one, so push stays high between items unless a gap is drawn
  int idle_odds;
  task automatic send_byte(input logic [7:0] b);
    if (!calm && !holding && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    push    <= 1'b1;
    byte_in <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // byte side: reset, directed bytes, then random tokens
  initial begin : drive_bytes
    int n;
    rst_ni     = 1'b0;
    push       = 1'b0;
    byte_in    = 8'h00;
    calm       = 1'b0;
    reset_done = 1'b0;
    idle_odds  = 0;
    bytes_sent = 0;

    // directed opening: ascii extremes, end of string, escaped quote,
    // \u with a digit outside the hex set, unknown escape, bad leads,
    // smallest two-byte point, largest point as a surrogate pair,
    // bad second byte after e0, smallest supplementary point, closing quote
    byte_plan = {8'h00, 8'h7f, CH_QUOTE, CH_BACKSLASH, CH_QUOTE,
                 CH_BACKSLASH, CH_U, 8'("D"), 8'("8"), 8'("z"), 8'("0"),
                 CH_BACKSLASH, 8'("q"), 8'hff, 8'hc1,
                 8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
                 LEAD_E0, 8'h9f, LEAD_F0, 8'h90, 8'h80, 8'h80, CH_QUOTE};
    n = byte_plan.size();
    while (byte_plan.size() < n + RandomBytes) plan_token();
    byte_plan.push_back(CH_QUOTE);

    repeat (4) @(negedge clk_i);
    rst_ni     <= 1'b1;
    reset_done  = 1'b1;

    for (n = 0; n < byte_plan.size(); n++) begin
      calm = (n >= byte_plan.size() - CalmTail);
      // change the gap density now and then, zero gives unbroken runs
      if (n % 100 == 0) idle_odds = $urandom_range(0, 2) * 4;
      send_byte(byte_plan[n]);
    end
    push <= 1'b0;

    // let every expected result arrive, then watch a little longer for extras
    while (units_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("decoded %0d string body bytes into %0d checked results",
             bytes_taken, results_taken);
    $display("%0d surrogate code units and %0d end or error markers, output held off twice",
             surrogates, markers);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stall bursts, two long hold-offs to back up the queue
  initial begin : drain_results
    int hold_at;
    int stall_odds;
    int iter;
    pop        = 1'b0;
    holding    = 1'b0;
    hold_at    = 150;
    stall_odds = 0;
    iter       = 0;
    wait (reset_done);
    forever begin
      @(negedge clk_i);
      iter++;
      if (iter % 64 == 0) stall_odds = $urandom_range(0, 2) * 3;
      if (hold_at != 0 && bytes_sent >= hold_at) begin
        // the sender keeps offering while this lasts, so full must rise
        holding = 1'b1;
        pop    <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        holding = 1'b0;
        hold_at = (hold_at < 400) ? 450 : 0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        // stall burst with pop held low
        pop <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: too long without any handshake on either side ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no byte or result accepted for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
